// ===== sv/sbs_pkg.sv =====
// Shared types, register indexes and reset values for the spectrum bar smoother.
package sbs_pkg;

    localparam int BIN_COUNT_DEF  = 32;
    localparam int LEVEL_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_ATTACK       = 3'd1;
    localparam logic [2:0] REG_RELEASE      = 3'd2;
    localparam logic [2:0] REG_DECAY        = 3'd3;
    localparam logic [2:0] REG_TICK_PERIOD  = 3'd4;
    localparam logic [2:0] REG_STALE_LIMIT  = 3'd5;
    localparam logic [2:0] REG_DEADBAND     = 3'd6;
    localparam logic [2:0] REG_ENERGY_FLOOR = 3'd7;

    // opcodes carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // reset values
    localparam logic        ENABLE_RST       = 1'b1;
    localparam logic [15:0] ATTACK_RST       = 16'd36045;
    localparam logic [15:0] RELEASE_RST      = 16'd9175;
    localparam logic [15:0] DECAY_RST        = 16'd57672;
    localparam logic [6:0]  TICK_PERIOD_RST  = 7'd16;
    localparam logic [9:0]  STALE_LIMIT_RST  = 10'd250;
    localparam logic [15:0] DEADBAND_RST     = 16'd33;
    localparam logic [15:0] ENERGY_FLOOR_RST = 16'd1311;

    localparam logic [9:0]  IDLE_MAX = 10'd1023;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SM_MUL,
        ST_SM_UPD,
        ST_EMIT,
        ST_AGE,
        ST_DC_MUL,
        ST_DC_UPD
    } state_t;

endpackage

// ===== sv/sbs_mul.sv =====
// Shared fractional multiplier: registered floor(a * b / 65536).
module sbs_mul #(
    parameter int LEVEL_BITS = sbs_pkg::LEVEL_BITS_DEF
) (
    input  logic                  clk,
    input  logic [LEVEL_BITS-1:0] op_a,
    input  logic [15:0]           op_b,
    output logic [LEVEL_BITS-1:0] prod_q
);

    logic [LEVEL_BITS+15:0] prod;
    logic [LEVEL_BITS-1:0]  prod_reg;

    assign prod = (LEVEL_BITS+16)'(op_a) * (LEVEL_BITS+16)'(op_b);

    // b is below one, so the scaled product never exceeds a
    always_ff @(posedge clk)
    begin
        prod_reg <= prod[LEVEL_BITS+15:16];
    end

    assign prod_q = prod_reg;

endmodule

// ===== sv/spectrum_bar_smoother_unit.sv =====
// Top level of the spectrum bar smoother: sequencer, level store and ports.
//
// Input channel s_*: s_tuser is the opcode (load or tick), s_tdata carries the
// bin index and the Q0.16 level. A load writes one target and emits nothing.
// A tick, once a level is loaded, walks all bins through one shared multiplier
// under a small sequencer; s_tready stays low until the tick has finished:
//   smoothing   per bin: multiply, then write back
//   frame       one item per bin, only when a display level changed
//   ageing      idle time advances by the tick period
//   decay       per bin: multiply, then write back, only once idle time passes the stale limit
//   zero frame  one item per bin, only when no target keeps any energy
// Output channel m_*: one item per bin, m_tlast on the last bin of a frame.
// Items sit in an output register; a stall on m_tready holds the frame walk
// and the item, nothing is lost. Configuration writes on cfg_* are taken only
// while the sequencer is idle, and hold off s_* in that cycle; clearing
// enable wipes the store at once.
// Reset (rst_n low, asynchronous) loads the default register values and
// clears every target, display level, the available flag and the idle time.
module spectrum_bar_smoother_unit #(
    parameter int BIN_COUNT  = sbs_pkg::BIN_COUNT_DEF,
    parameter int LEVEL_BITS = sbs_pkg::LEVEL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bin_index[4:0], level_in[20:5], zero fill
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // bin_out[4:0], level_out[20:5], zero fill
    output logic        m_tlast,   // last_bin
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDXW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int LB    = LEVEL_BITS;
    localparam int UP_SH = (LB >= 16) ? LB - 16 : 0;
    localparam int DN_SH = (LB >= 16) ? 0 : 16 - LB;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BIN_COUNT - 1);
    localparam logic [5:0]      BIN_LIM  = 6'(BIN_COUNT);

    function automatic logic [LB-1:0] to_lvl(input logic [15:0] v);
        logic [LB+15:0] tmp;
        tmp = ((LB+16)'(v) << UP_SH) >> DN_SH;
        return tmp[LB-1:0];
    endfunction

    function automatic logic [15:0] to_q16(input logic [LB-1:0] v);
        logic [LB+15:0] tmp;
        tmp = ((LB+16)'(v) >> UP_SH) << DN_SH;
        return tmp[15:0];
    endfunction

    // configuration
    logic        enable_reg;
    logic [15:0] attack_reg, release_reg, decay_reg, deadband_reg, floor_reg;
    logic [6:0]  tick_period_reg;
    logic [9:0]  stale_limit_reg;

    // store and control
    logic [LB-1:0]   target_reg  [BIN_COUNT];
    logic [LB-1:0]   display_reg [BIN_COUNT];
    logic            avail_reg, avail_next;
    logic [9:0]      idle_reg, idle_next;
    sbs_pkg::state_t state_reg, state_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic            changed_reg, changed_next;
    logic            energy_reg, energy_next;
    logic            zero_frame_reg, zero_frame_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [IDXW-1:0] m_bin_reg, m_bin_next;
    logic [15:0]     m_level_reg, m_level_next;
    logic            m_last_reg, m_last_next;

    logic            in_fire, cfg_fire, is_last, out_free;
    logic [4:0]      in_bin;
    logic [LB-1:0]   cur_t, cur_d, err, step, mul_a, db_lvl, floor_lvl;
    logic [15:0]     mul_b;
    logic            t_gt_d, err_ge;
    logic [10:0]     idle_sum;
    logic [9:0]      idle_sat;
    logic            clear_store, tgt_we, disp_we;
    logic [IDXW-1:0] tgt_waddr;
    logic [LB-1:0]   tgt_wdata, disp_wdata;

    assign in_fire  = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    // registers only change between items
    assign cfg_ready = (state_reg == sbs_pkg::ST_IDLE);
    assign in_bin   = s_tdata[4:0];
    assign is_last  = (idx_reg == LAST_IDX);
    assign out_free = !m_tvalid_reg || m_tready;

    assign cur_t     = target_reg[idx_reg];
    assign cur_d     = display_reg[idx_reg];
    assign t_gt_d    = cur_t > cur_d;
    assign err       = t_gt_d ? cur_t - cur_d : cur_d - cur_t;
    assign db_lvl    = to_lvl(deadband_reg);
    assign floor_lvl = to_lvl(floor_reg);
    assign err_ge    = err >= db_lvl;

    assign idle_sum = 11'(idle_reg) + 11'(tick_period_reg);
    assign idle_sat = (idle_sum > 11'(sbs_pkg::IDLE_MAX)) ? sbs_pkg::IDLE_MAX
                                                            : idle_sum[9:0];

    // shared multiplier: smoothing step or target decay
    assign mul_a = (state_reg == sbs_pkg::ST_DC_MUL) ? cur_t : err;
    assign mul_b = (state_reg == sbs_pkg::ST_DC_MUL) ? decay_reg
                 : (t_gt_d ? attack_reg : release_reg);

    sbs_mul #(
        .LEVEL_BITS(LEVEL_BITS)
    ) u_mul (
        .clk   (clk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod_q(step)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbs_pkg::ST_IDLE:
            begin
                if (in_fire && enable_reg && s_tuser == sbs_pkg::OP_TICK && avail_reg)
                    state_next = sbs_pkg::ST_SM_MUL;
            end
            sbs_pkg::ST_SM_MUL:
                state_next = sbs_pkg::ST_SM_UPD;
            sbs_pkg::ST_SM_UPD:
            begin
                if (!is_last)
                    state_next = sbs_pkg::ST_SM_MUL;
                else if (changed_reg || err_ge)
                    state_next = sbs_pkg::ST_EMIT;
                else
                    state_next = sbs_pkg::ST_AGE;
            end
            sbs_pkg::ST_EMIT:
            begin
                if (out_free && is_last)
                    state_next = zero_frame_reg ? sbs_pkg::ST_IDLE : sbs_pkg::ST_AGE;
            end
            sbs_pkg::ST_AGE:
                state_next = (idle_sat > stale_limit_reg) ? sbs_pkg::ST_DC_MUL
                                                          : sbs_pkg::ST_IDLE;
            sbs_pkg::ST_DC_MUL:
                state_next = sbs_pkg::ST_DC_UPD;
            sbs_pkg::ST_DC_UPD:
            begin
                if (!is_last)
                    state_next = sbs_pkg::ST_DC_MUL;
                else if (energy_reg || step > floor_lvl)
                    state_next = sbs_pkg::ST_IDLE;
                else
                    state_next = sbs_pkg::ST_EMIT;
            end
            default:
                state_next = sbs_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_tready        = (state_reg == sbs_pkg::ST_IDLE) && !cfg_valid;
        idx_next        = idx_reg;
        changed_next    = changed_reg;
        energy_next     = energy_reg;
        zero_frame_next = zero_frame_reg;
        avail_next      = avail_reg;
        idle_next       = idle_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_bin_next      = m_bin_reg;
        m_level_next    = m_level_reg;
        m_last_next     = m_last_reg;
        clear_store     = 1'b0;
        tgt_we          = 1'b0;
        tgt_waddr       = idx_reg;
        tgt_wdata       = step;
        disp_we         = 1'b0;
        disp_wdata      = t_gt_d ? cur_d + step : cur_d - step;
        unique case (state_reg)
            sbs_pkg::ST_IDLE:
            begin
                idx_next        = '0;
                changed_next    = 1'b0;
                energy_next     = 1'b0;
                zero_frame_next = 1'b0;
                if (in_fire && enable_reg && s_tuser == sbs_pkg::OP_LOAD
                    && {1'b0, in_bin} < BIN_LIM)
                begin
                    tgt_we     = 1'b1;
                    tgt_waddr  = in_bin[IDXW-1:0];
                    tgt_wdata  = to_lvl(s_tdata[20:5]);
                    avail_next = 1'b1;
                    idle_next  = '0;
                end
            end
            sbs_pkg::ST_SM_MUL:
            begin
            end
            sbs_pkg::ST_SM_UPD:
            begin
                if (err_ge)
                begin
                    disp_we      = 1'b1;
                    changed_next = 1'b1;
                end
                idx_next = is_last ? '0 : idx_reg + 1'b1;
            end
            sbs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_bin_next    = idx_reg;
                    m_level_next  = to_q16(cur_d);
                    m_last_next   = is_last;
                    idx_next      = is_last ? '0 : idx_reg + 1'b1;
                end
            end
            sbs_pkg::ST_AGE:
            begin
                idle_next = idle_sat;
                idx_next  = '0;
            end
            sbs_pkg::ST_DC_MUL:
            begin
            end
            sbs_pkg::ST_DC_UPD:
            begin
                tgt_we = 1'b1;
                if (step > floor_lvl)
                    energy_next = 1'b1;
                idx_next = is_last ? '0 : idx_reg + 1'b1;
                if (is_last && !(energy_reg || step > floor_lvl))
                begin
                    // no energy left: wipe the store, then send a frame of zeros
                    clear_store     = 1'b1;
                    zero_frame_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (cfg_fire && cfg_index == sbs_pkg::REG_ENABLE && enable_reg && !cfg_data[0])
            clear_store = 1'b1;
        if (clear_store)
        begin
            avail_next = 1'b0;
            idle_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sbs_pkg::ST_IDLE;
            idx_reg        <= '0;
            changed_reg    <= 1'b0;
            energy_reg     <= 1'b0;
            zero_frame_reg <= 1'b0;
            avail_reg      <= 1'b0;
            idle_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            changed_reg    <= changed_next;
            energy_reg     <= energy_next;
            zero_frame_reg <= zero_frame_next;
            avail_reg      <= avail_next;
            idle_reg       <= idle_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_bin_reg   <= m_bin_next;
        m_level_reg <= m_level_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                target_reg[i]  <= '0;
                display_reg[i] <= '0;
            end
        end
        else if (clear_store)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                target_reg[i]  <= '0;
                display_reg[i] <= '0;
            end
        end
        else
        begin
            if (tgt_we)
                target_reg[tgt_waddr] <= tgt_wdata;
            if (disp_we)
                display_reg[idx_reg] <= disp_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= sbs_pkg::ENABLE_RST;
            attack_reg      <= sbs_pkg::ATTACK_RST;
            release_reg     <= sbs_pkg::RELEASE_RST;
            decay_reg       <= sbs_pkg::DECAY_RST;
            tick_period_reg <= sbs_pkg::TICK_PERIOD_RST;
            stale_limit_reg <= sbs_pkg::STALE_LIMIT_RST;
            deadband_reg    <= sbs_pkg::DEADBAND_RST;
            floor_reg       <= sbs_pkg::ENERGY_FLOOR_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                sbs_pkg::REG_ENABLE:       enable_reg      <= cfg_data[0];
                sbs_pkg::REG_ATTACK:       attack_reg      <= cfg_data;
                sbs_pkg::REG_RELEASE:      release_reg     <= cfg_data;
                sbs_pkg::REG_DECAY:        decay_reg       <= cfg_data;
                sbs_pkg::REG_TICK_PERIOD:  tick_period_reg <= cfg_data[6:0];
                sbs_pkg::REG_STALE_LIMIT:  stale_limit_reg <= cfg_data[9:0];
                sbs_pkg::REG_DEADBAND:     deadband_reg    <= cfg_data;
                sbs_pkg::REG_ENERGY_FLOOR: floor_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_level_reg, 5'(m_bin_reg)};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_last_on_final_bin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[4:0] == 5'(BIN_COUNT - 1))))
        else $error("tlast does not match the final bin");

    a_clear_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        clear_store |=> (!avail_reg && idle_reg == '0))
        else $error("store clear left spectrum available or idle time");

    a_disabled_tick_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !enable_reg) |=> (state_reg == sbs_pkg::ST_IDLE))
        else $error("item taken while disabled started a pass");
`endif

endmodule

// ===== verif/spectrum_bar_smoother_unit_tb.sv =====
// Self-checking testbench for the spectrum bar smoother: directed and random items.
module spectrum_bar_smoother_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS          = sbs_pkg::BIN_COUNT_DEF;
    localparam int SETTLE_CYCLES = 256;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [4:0]  bar_bin;
        logic [15:0] level;
        logic        last;
    } bar_item_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = sbs_pkg::OP_LOAD;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = sbs_pkg::REG_ENABLE;
    logic [15:0] cfg_data  = '0;

    spectrum_bar_smoother_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the block's registers and level store
    logic        en_q;
    logic [15:0] atk_coeff;
    logic [15:0] rel_coeff;
    logic [15:0] dec_coeff;
    logic [6:0]  period_ms;
    logic [9:0]  stale_ms;
    logic [15:0] dead_band;
    logic [15:0] floor_level;
    logic [15:0] target_q [BINS];
    logic [15:0] shown_q [BINS];
    logic        have_spectrum;
    logic [9:0]  idle_ms_q;

    bar_item_t pending_bars[$];
    bar_item_t got_bar;
    bar_item_t want_bar;
    int        bad_bars = 0;
    int        cycles   = 0;
    bit        calm     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls in short bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_bar.bar_bin = m_tdata[4:0];
            got_bar.level   = m_tdata[20:5];
            got_bar.last    = m_tlast;
            if (pending_bars.size() == 0)
            begin
                bad_bars++;
                if (bad_bars <= 10)
                    $display("unexpected bar item: bin %0d level %h last %b",
                             got_bar.bar_bin, got_bar.level, got_bar.last);
            end
            else
            begin
                want_bar = pending_bars.pop_front();
                if (got_bar.bar_bin != want_bar.bar_bin || got_bar.level != want_bar.level
                    || got_bar.last != want_bar.last)
                begin
                    bad_bars++;
                    if (bad_bars <= 10)
                    begin
                        $display("bar mismatch: expected bin %0d level %h last %b",
                                 want_bar.bar_bin, want_bar.level, want_bar.last);
                        $display("              got bin %0d level %h last %b",
                                 got_bar.bar_bin, got_bar.level, got_bar.last);
                    end
                end
            end
        end
    end

    function automatic void clear_bars();
        for (int i = 0; i < BINS; i++)
        begin
            target_q[i] = '0;
            shown_q[i]  = '0;
        end
        have_spectrum = 1'b0;
        idle_ms_q     = '0;
    endfunction

    function automatic void queue_frame(bit zeros);
        bar_item_t b;
        for (int i = 0; i < BINS; i++)
        begin
            b.bar_bin = i[4:0];
            b.level   = zeros ? 16'd0 : shown_q[i];
            b.last    = (i == BINS - 1);
            pending_bars.push_back(b);
        end
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            sbs_pkg::REG_ENABLE:
            begin
                if (en_q && !val[0])
                    clear_bars();
                en_q = val[0];
            end
            sbs_pkg::REG_ATTACK:       atk_coeff   = val;
            sbs_pkg::REG_RELEASE:      rel_coeff   = val;
            sbs_pkg::REG_DECAY:        dec_coeff   = val;
            sbs_pkg::REG_TICK_PERIOD:  period_ms   = val[6:0];
            sbs_pkg::REG_STALE_LIMIT:  stale_ms    = val[9:0];
            sbs_pkg::REG_DEADBAND:     dead_band   = val;
            sbs_pkg::REG_ENERGY_FLOOR: floor_level = val;
            default: ;
        endcase
    endfunction

    // one accepted item: a load, or a tick's smoothing walk, frame, ageing, decay and energy check
    function automatic void smooth_bars(logic op, logic [4:0] bin, logic [15:0] lvl);
        int unsigned t;
        int unsigned d;
        int unsigned err;
        int unsigned step;
        int unsigned idle_sum;
        bit          changed;
        bit          energy;
        changed = 1'b0;
        energy  = 1'b0;
        if (!en_q)
            return;
        if (op == sbs_pkg::OP_LOAD)
        begin
            target_q[bin] = lvl;
            have_spectrum = 1'b1;
            idle_ms_q     = '0;
            return;
        end
        if (!have_spectrum)
            return;
        for (int i = 0; i < BINS; i++)
        begin
            t   = target_q[i];
            d   = shown_q[i];
            err = (t > d) ? t - d : d - t;
            if (err >= dead_band)
            begin
                changed = 1'b1;
                if (t > d)
                begin
                    step       = (err * atk_coeff) >> 16;
                    shown_q[i] = 16'(d + step);
                end
                else
                begin
                    step       = (err * rel_coeff) >> 16;
                    shown_q[i] = 16'(d - step);
                end
            end
        end
        if (changed)
            queue_frame(1'b0);
        idle_sum  = idle_ms_q + period_ms;
        idle_ms_q = (idle_sum > sbs_pkg::IDLE_MAX) ? sbs_pkg::IDLE_MAX : idle_sum[9:0];
        if (idle_ms_q > stale_ms)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                t           = (target_q[i] * dec_coeff) >> 16;
                target_q[i] = t[15:0];
                if (t > floor_level)
                    energy = 1'b1;
            end
            if (!energy)
            begin
                clear_bars();
                queue_frame(1'b1);
            end
        end
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op, logic [4:0] bin, logic [15:0] lvl);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, lvl, bin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        smooth_bars(op, bin, lvl);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every expected item, then let a silent tick run out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_random_config(bit wipe);
        logic [15:0] v;
        if (wipe)
            write_reg(sbs_pkg::REG_ENABLE, 16'd0);
        write_reg(sbs_pkg::REG_ENABLE, 16'd1);
        write_reg(sbs_pkg::REG_ATTACK, pick_q16());
        write_reg(sbs_pkg::REG_RELEASE, pick_q16());
        write_reg(sbs_pkg::REG_DECAY, pick_q16());
        case ($urandom_range(0, 3))
            0:       v = 16'd0;
            1:       v = 16'd127;
            default: v = 16'($urandom_range(16, 66));
        endcase
        write_reg(sbs_pkg::REG_TICK_PERIOD, v);
        case ($urandom_range(0, 3))
            0:       v = 16'd0;
            1:       v = 16'd1023;
            default: v = 16'($urandom_range(0, 1023));
        endcase
        write_reg(sbs_pkg::REG_STALE_LIMIT, v);
        // mostly small deadbands so that frames keep coming
        v = ($urandom_range(0, 4) == 0) ? pick_q16() : 16'($urandom_range(0, 200));
        write_reg(sbs_pkg::REG_DEADBAND, v);
        v = ($urandom_range(0, 4) == 0) ? pick_q16() : 16'($urandom_range(0, 3000));
        write_reg(sbs_pkg::REG_ENERGY_FLOOR, v);
    endtask

    task automatic run_phase(int items, bit wipe);
        int sent;
        int loads;
        int ticks;
        sent = 0;
        settle();
        set_random_config(wipe);
        while (sent < items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                loads = $urandom_range(1, 8);
                ticks = $urandom_range(1, 5);
                repeat (loads) send_item(sbs_pkg::OP_LOAD, 5'($urandom), rand_level());
                repeat (ticks) send_item(sbs_pkg::OP_TICK, 5'($urandom), 16'($urandom));
                sent += loads + ticks;
            end
            else
            begin
                send_item(1'($urandom), 5'($urandom), rand_level());
                sent++;
            end
        end
    endtask

    task automatic test_tick_without_spectrum();
        send_item(sbs_pkg::OP_TICK, 5'd31, 16'hFFFF);
    endtask

    task automatic test_load_and_smooth();
        send_item(sbs_pkg::OP_LOAD, 5'd0, 16'h0000);
        send_item(sbs_pkg::OP_LOAD, 5'd31, 16'hFFFF);
        send_item(sbs_pkg::OP_LOAD, 5'd10, 16'h8000);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
        settle();
        write_reg(sbs_pkg::REG_ATTACK, 16'hFFFF);
        write_reg(sbs_pkg::REG_RELEASE, 16'h0000);
        send_item(sbs_pkg::OP_LOAD, 5'd31, 16'h0000);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
        settle();
        write_reg(sbs_pkg::REG_ATTACK, 16'h0000);
        write_reg(sbs_pkg::REG_RELEASE, 16'hFFFF);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
    endtask

    task automatic test_deadband_extremes();
        settle();
        write_reg(sbs_pkg::REG_DEADBAND, 16'h0000);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
        settle();
        write_reg(sbs_pkg::REG_DEADBAND, 16'hFFFF);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
    endtask

    task automatic test_disable_wipes();
        settle();
        write_reg(sbs_pkg::REG_ENABLE, 16'd0);
        send_item(sbs_pkg::OP_LOAD, 5'd3, 16'h1234);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
        settle();
        write_reg(sbs_pkg::REG_ENABLE, 16'd1);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
    endtask

    task automatic test_energy_gone();
        settle();
        write_reg(sbs_pkg::REG_DEADBAND, 16'd33);
        write_reg(sbs_pkg::REG_STALE_LIMIT, 16'd0);
        write_reg(sbs_pkg::REG_DECAY, 16'h0000);
        write_reg(sbs_pkg::REG_ENERGY_FLOOR, 16'h0000);
        send_item(sbs_pkg::OP_LOAD, 5'd5, 16'h1234);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
        settle();
        // a full-scale floor can never be exceeded
        write_reg(sbs_pkg::REG_DECAY, 16'hFFFF);
        write_reg(sbs_pkg::REG_ENERGY_FLOOR, 16'hFFFF);
        send_item(sbs_pkg::OP_LOAD, 5'd7, 16'hFFFF);
        send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
    endtask

    task automatic test_idle_saturation();
        settle();
        write_reg(sbs_pkg::REG_STALE_LIMIT, 16'd1023);
        write_reg(sbs_pkg::REG_TICK_PERIOD, 16'd127);
        write_reg(sbs_pkg::REG_DECAY, 16'h0000);
        write_reg(sbs_pkg::REG_ENERGY_FLOOR, 16'h0000);
        send_item(sbs_pkg::OP_LOAD, 5'd9, 16'h4000);
        repeat (9) send_item(sbs_pkg::OP_TICK, 5'd0, 16'h0000);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
            run_phase(38, p % 3 == 1);
    endtask

    task automatic test_steady_traffic();
        settle();
        calm = 1'b1;
        run_phase(38, 1'b0);
    endtask

    initial
    begin
        en_q        = sbs_pkg::ENABLE_RST;
        atk_coeff   = sbs_pkg::ATTACK_RST;
        rel_coeff   = sbs_pkg::RELEASE_RST;
        dec_coeff   = sbs_pkg::DECAY_RST;
        period_ms   = sbs_pkg::TICK_PERIOD_RST;
        stale_ms    = sbs_pkg::STALE_LIMIT_RST;
        dead_band   = sbs_pkg::DEADBAND_RST;
        floor_level = sbs_pkg::ENERGY_FLOOR_RST;
        clear_bars();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tick_without_spectrum();
        test_load_and_smooth();
        test_deadband_extremes();
        test_disable_wipes();
        test_energy_gone();
        test_idle_saturation();
        test_random_traffic();
        test_steady_traffic();
        settle();

        if (bad_bars == 0 && pending_bars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
